@@ design/rt2d_pkg.sv @@
// ----------------------------------------------------------------------------
// rt2d_pkg: shared definitions for the 2D rigid transform unit
// Widths, operation codes, the quarter-wave sine table and the trig types.
// ----------------------------------------------------------------------------
package rt2d_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int COORD_BITS = 32;

  // Angles are widened to a fixed phase before the table lookup.
  localparam int PHASE_BITS = 24;
  localparam int QTR_BITS   = 22;
  localparam int FRAC_BITS  = 17;
  localparam int IDX_BITS   = QTR_BITS - FRAC_BITS + 1;
  localparam int TRIG_BITS  = 16;
  localparam int DELTA_BITS = 12;
  localparam int TAB_LAST   = 32;

  localparam logic [TRIG_BITS-1:0] TRIG_MAX = 16'd32767;

  localparam logic [1:0] OP_LOCAL_TO_GLOBAL = 2'd0;
  localparam logic [1:0] OP_GLOBAL_TO_LOCAL = 2'd1;
  localparam logic [1:0] OP_COMPOSE         = 2'd2;
  localparam logic [1:0] OP_NONE            = 2'd3;

  typedef logic signed [TRIG_BITS-1:0] trig_t;

  typedef struct packed {
    trig_t sin_v;
    trig_t cos_v;
  } rt2d_trig_t;

  // One table fetch: base value, step to the next entry, position between them.
  typedef struct packed {
    logic [TRIG_BITS-1:0]  base;
    logic [DELTA_BITS-1:0] delta;
    logic [FRAC_BITS-1:0]  frac;
    logic                  neg;
  } rt2d_fetch_t;

  // Sine over a quarter turn in 32 steps; the last entry is capped at 32767.
  function automatic logic [TRIG_BITS-1:0] quarter_sine(input logic [IDX_BITS-1:0] idx);
    logic [TRIG_BITS-1:0] v;
    case (idx)
      6'd0:    v = 16'd0;
      6'd1:    v = 16'd1608;
      6'd2:    v = 16'd3212;
      6'd3:    v = 16'd4808;
      6'd4:    v = 16'd6393;
      6'd5:    v = 16'd7962;
      6'd6:    v = 16'd9512;
      6'd7:    v = 16'd11039;
      6'd8:    v = 16'd12540;
      6'd9:    v = 16'd14010;
      6'd10:   v = 16'd15447;
      6'd11:   v = 16'd16846;
      6'd12:   v = 16'd18205;
      6'd13:   v = 16'd19520;
      6'd14:   v = 16'd20788;
      6'd15:   v = 16'd22006;
      6'd16:   v = 16'd23170;
      6'd17:   v = 16'd24279;
      6'd18:   v = 16'd25330;
      6'd19:   v = 16'd26320;
      6'd20:   v = 16'd27245;
      6'd21:   v = 16'd28106;
      6'd22:   v = 16'd28899;
      6'd23:   v = 16'd29622;
      6'd24:   v = 16'd30273;
      6'd25:   v = 16'd30852;
      6'd26:   v = 16'd31357;
      6'd27:   v = 16'd31786;
      6'd28:   v = 16'd32138;
      6'd29:   v = 16'd32413;
      6'd30:   v = 16'd32610;
      6'd31:   v = 16'd32729;
      default: v = TRIG_MAX;
    endcase
    return v;
  endfunction

endpackage

@@ design/rt2d_sincos.sv @@
// ----------------------------------------------------------------------------
// rt2d_sincos: two-stage sine and cosine generator
// Table fetch in the first stage, linear interpolation and sign in the second.
// ----------------------------------------------------------------------------
module rt2d_sincos (
  input  logic                             clk,
  input  logic                             adv,
  input  logic [rt2d_pkg::ANGLE_BITS-1:0]  angle,
  output rt2d_pkg::rt2d_trig_t             trig
);
  import rt2d_pkg::*;

  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  rt2d_fetch_t sin_f;
  rt2d_fetch_t cos_f;

  // Fold the angle into the first quadrant and read the two table entries around it.
  function automatic rt2d_fetch_t fetch(input logic [ANGLE_BITS-1:0] a);
    logic [PHASE_BITS-1:0] phase;
    logic [QTR_BITS:0]     p;
    logic [IDX_BITS-1:0]   idx;
    rt2d_fetch_t           r;
    phase = PHASE_BITS'(a) << (PHASE_BITS - ANGLE_BITS);
    p = {1'b0, phase[QTR_BITS-1:0]};
    if (phase[QTR_BITS]) begin
      p = {1'b1, {QTR_BITS{1'b0}}} - p;
    end
    idx = p[QTR_BITS:FRAC_BITS];
    if (idx >= IDX_BITS'(TAB_LAST)) begin
      r.base  = TRIG_MAX;
      r.delta = '0;
    end else begin
      r.base  = quarter_sine(idx);
      r.delta = DELTA_BITS'(quarter_sine(IDX_BITS'(idx + 1'b1)) - quarter_sine(idx));
    end
    r.frac = p[FRAC_BITS-1:0];
    r.neg  = phase[PHASE_BITS-1];
    return r;
  endfunction

  function automatic trig_t interp(input rt2d_fetch_t f);
    logic [DELTA_BITS+FRAC_BITS:0] prod;
    logic [TRIG_BITS-1:0]          mag;
    prod = (DELTA_BITS + FRAC_BITS + 1)'(f.delta * f.frac)
         + (DELTA_BITS + FRAC_BITS + 1)'(1 << (FRAC_BITS - 1));
    mag = f.base + TRIG_BITS'(prod >> FRAC_BITS);
    return f.neg ? trig_t'(-mag) : trig_t'(mag);
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      sin_f <= fetch(angle);
      cos_f <= fetch(angle + QUARTER_TURN);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      trig.sin_v <= interp(sin_f);
      trig.cos_v <= interp(cos_f);
    end
  end

endmodule

@@ design/rigid_transform_2d_unit.sv @@
// ----------------------------------------------------------------------------
// rigid_transform_2d_unit: fixed-point 2D rigid-body transform
// Five-stage pipeline that moves a point or pose through a frame pose.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle while in_stall is low. An accepted item
// moves through the stage A, B, C and D registers into the output register.
// Coordinates are signed
// Q15.16, angles are binary (a full turn is 2^16) and sine and cosine are
// Q1.15 values from an interpolated quarter-wave table. Opcode 0 maps a local
// point to global, opcode 1 maps a global point to local, opcode 2 composes a
// pose (the headings are summed and wrap round), and opcode 3 gives an all-zero
// result. Each coordinate is rounded once and then clipped to the 32-bit range;
// the saturated flag reports a clip on either axis. The stages are: operand
// select and table fetch, interpolation, four 33 by 16 bit products, sum with
// rounding and offset, and saturation into the output register. All stages
// advance together; when the output holds an item that is stalled, the whole
// pipeline holds and in_stall is raised, so the figure of one item per cycle
// is set by the single shared advance of the stages.
module rigid_transform_2d_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             opcode,
  input  logic signed [rt2d_pkg::COORD_BITS-1:0] point_x,
  input  logic signed [rt2d_pkg::COORD_BITS-1:0] point_y,
  input  logic [rt2d_pkg::ANGLE_BITS-1:0]        point_heading,
  input  logic signed [rt2d_pkg::COORD_BITS-1:0] frame_x,
  input  logic signed [rt2d_pkg::COORD_BITS-1:0] frame_y,
  input  logic [rt2d_pkg::ANGLE_BITS-1:0]        frame_heading,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rt2d_pkg::COORD_BITS-1:0] result_x,
  output logic signed [rt2d_pkg::COORD_BITS-1:0] result_y,
  output logic [rt2d_pkg::ANGLE_BITS-1:0]        result_heading,
  output logic                                   saturated
);
  import rt2d_pkg::*;

  // Widths of the datapath: operand, product, sum, rounded sum, sum with offset.
  localparam int UW = COORD_BITS + 1;
  localparam int PW = UW + TRIG_BITS;
  localparam int SW = PW + 1;
  localparam int RSHIFT = TRIG_BITS - 1;
  localparam int RW = SW - RSHIFT;
  localparam int OW = RW + 1;

  localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) << (RSHIFT - 1);
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic adv;

  // Stage A: operands selected, offsets chosen, heading summed for compose and zero otherwise.
  logic                         a_valid;
  logic [1:0]                   a_op;
  logic [ANGLE_BITS-1:0]        a_head;
  logic signed [UW-1:0]         a_u;
  logic signed [UW-1:0]         a_v;
  logic signed [COORD_BITS-1:0] a_ox;
  logic signed [COORD_BITS-1:0] a_oy;

  // Stage B: data waits while the sine and cosine are interpolated.
  logic                         b_valid;
  logic [1:0]                   b_op;
  logic [ANGLE_BITS-1:0]        b_head;
  logic signed [UW-1:0]         b_u;
  logic signed [UW-1:0]         b_v;
  logic signed [COORD_BITS-1:0] b_ox;
  logic signed [COORD_BITS-1:0] b_oy;
  rt2d_trig_t                   trig;

  // Stage C: the four rotation products.
  logic                         c_valid;
  logic [1:0]                   c_op;
  logic [ANGLE_BITS-1:0]        c_head;
  logic signed [PW-1:0]         c_cu;
  logic signed [PW-1:0]         c_sv;
  logic signed [PW-1:0]         c_su;
  logic signed [PW-1:0]         c_cv;
  logic signed [COORD_BITS-1:0] c_ox;
  logic signed [COORD_BITS-1:0] c_oy;

  // Stage D: rounded sums with the frame offset added.
  logic                         d_valid;
  logic [1:0]                   d_op;
  logic [ANGLE_BITS-1:0]        d_head;
  logic signed [OW-1:0]         d_x;
  logic signed [OW-1:0]         d_y;

  logic signed [SW-1:0]         sum_x;
  logic signed [SW-1:0]         sum_y;
  logic signed [SW-1:0]         rnd_x;
  logic signed [SW-1:0]         rnd_y;
  logic signed [OW-1:0]         d_x_next;
  logic signed [OW-1:0]         d_y_next;

  logic signed [COORD_BITS-1:0] sat_x;
  logic signed [COORD_BITS-1:0] sat_y;
  logic                         clip_x;
  logic                         clip_y;

  // The whole pipeline moves unless a finished item is waiting at the output.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      out_valid <= d_valid;
    end
  end

  // Going from global to local removes the origin before rotating; the other
  // operations rotate the point as given and add the origin afterwards.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_op   <= opcode;
      a_head <= (opcode == OP_COMPOSE) ? ANGLE_BITS'(point_heading + frame_heading) : '0;
      if (opcode == OP_GLOBAL_TO_LOCAL) begin
        a_u  <= UW'(point_x) - UW'(frame_x);
        a_v  <= UW'(point_y) - UW'(frame_y);
        a_ox <= '0;
        a_oy <= '0;
      end else begin
        a_u  <= UW'(point_x);
        a_v  <= UW'(point_y);
        a_ox <= frame_x;
        a_oy <= frame_y;
      end
    end
  end

  rt2d_sincos u_sincos (
    .clk   (clk),
    .adv   (adv),
    .angle (frame_heading),
    .trig  (trig)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      b_op   <= a_op;
      b_head <= a_head;
      b_u    <= a_u;
      b_v    <= a_v;
      b_ox   <= a_ox;
      b_oy   <= a_oy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_op   <= b_op;
      c_head <= b_head;
      c_cu   <= PW'(b_u) * PW'(trig.cos_v);
      c_sv   <= PW'(b_v) * PW'(trig.sin_v);
      c_su   <= PW'(b_u) * PW'(trig.sin_v);
      c_cv   <= PW'(b_v) * PW'(trig.cos_v);
      c_ox   <= b_ox;
      c_oy   <= b_oy;
    end
  end

  // The inverse rotation flips the sign of the sine terms. Adding half a step
  // and shifting right rounds each sum once onto the coordinate grid.
  always_comb begin
    if (c_op == OP_GLOBAL_TO_LOCAL) begin
      sum_x = SW'(c_cu) + SW'(c_sv);
      sum_y = SW'(c_cv) - SW'(c_su);
    end else begin
      sum_x = SW'(c_cu) - SW'(c_sv);
      sum_y = SW'(c_su) + SW'(c_cv);
    end
    rnd_x    = sum_x + ROUND_HALF;
    rnd_y    = sum_y + ROUND_HALF;
    d_x_next = OW'($signed(rnd_x[SW-1:RSHIFT])) + OW'(c_ox);
    d_y_next = OW'($signed(rnd_y[SW-1:RSHIFT])) + OW'(c_oy);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_op   <= c_op;
      d_head <= c_head;
      d_x    <= d_x_next;
      d_y    <= d_y_next;
    end
  end

  // A value fits when every bit above the coordinate's sign bit matches it.
  always_comb begin
    clip_x = !((&d_x[OW-1:COORD_BITS-1]) || !(|d_x[OW-1:COORD_BITS-1]));
    clip_y = !((&d_y[OW-1:COORD_BITS-1]) || !(|d_y[OW-1:COORD_BITS-1]));
    if (clip_x) begin
      sat_x = d_x[OW-1] ? COORD_MIN : COORD_MAX;
    end else begin
      sat_x = d_x[COORD_BITS-1:0];
    end
    if (clip_y) begin
      sat_y = d_y[OW-1] ? COORD_MIN : COORD_MAX;
    end else begin
      sat_y = d_y[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (d_op == OP_NONE) begin
        result_x       <= '0;
        result_y       <= '0;
        result_heading <= '0;
        saturated      <= 1'b0;
      end else begin
        result_x       <= sat_x;
        result_y       <= sat_y;
        result_heading <= d_head;
        saturated      <= clip_x || clip_y;
      end
    end
  end

`ifndef ASSERT_OFF
  a_hold_valids : assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable({a_valid, b_valid, c_valid, d_valid, out_valid}))
    else $error("pipeline valid bits moved while the output was stalled");

  a_heading_only_compose : assert property (@(posedge clk) disable iff (rst)
    adv && d_valid && d_op != OP_COMPOSE |=> result_heading == '0)
    else $error("heading set for an operation other than compose");

  a_unused_op_zero : assert property (@(posedge clk) disable iff (rst)
    adv && d_valid && d_op == OP_NONE |=> result_x == '0 && result_y == '0 && !saturated)
    else $error("unused opcode produced a non-zero result");

  a_sat_at_limit : assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> result_x == COORD_MAX || result_x == COORD_MIN ||
                               result_y == COORD_MAX || result_y == COORD_MIN)
    else $error("saturated flag set but no coordinate at a limit");
`endif

endmodule
